>>> rtl/core/t10dif_pkg.sv
// Shared types, constants and CRC functions of the T10 protection information checker.
package t10dif_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 4104;
  localparam int unsigned BLOCK_CAP       = (MAX_BLOCK_BYTES / 8) * 8;
  localparam int unsigned POS_W           = $clog2(MAX_BLOCK_BYTES / 8 + 1);
  localparam int unsigned LANES           = 8;

  localparam logic [15:0] CRC_POLY   = 16'h8BB7;
  localparam logic [15:0] ALL_ONES16 = 16'hFFFF;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  // Bit positions in mode_flags.
  localparam int unsigned FL_INV_SEED = 0;
  localparam int unsigned FL_INV_RES  = 1;
  localparam int unsigned FL_NO_GUARD = 2;
  localparam int unsigned FL_NO_REF   = 3;
  localparam int unsigned FL_FIX_REF  = 4;
  localparam int unsigned FL_INC_APP  = 5;
  localparam int unsigned FL_F_APP    = 6;
  localparam int unsigned FL_F_TAGS   = 7;
  localparam int unsigned FL_F_ALL    = 8;
  localparam int unsigned FL_F_ERR    = 9;

  // Bit positions in error_bits.
  localparam int unsigned EB_GUARD = 0;
  localparam int unsigned EB_REF   = 1;
  localparam int unsigned EB_APP   = 2;
  localparam int unsigned EB_ONES  = 3;

  typedef enum logic [2:0] {
    REG_BLOCK_BYTES = 3'd0,
    REG_MODE_FLAGS  = 3'd1,
    REG_APP_SEED    = 3'd2,
    REG_APP_MASK    = 3'd3,
    REG_REF_SEED    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIF_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_t;

  // Settings the tuple check needs from the register file.
  typedef struct packed {
    logic [9:0]  mode_flags;
    logic [15:0] app_mask;
  } chk_cfg_t;

  // Result item, status in the lowest bits.
  typedef struct packed {
    logic [31:0] error_offset;
    logic [3:0]  error_bits;
    logic [1:0]  status;
  } result_t;

  // One byte through the MSB-first CRC16 register.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // Moves a CRC state across n zero bytes, n no larger than LANES.
  function automatic logic [15:0] crc_advance(input logic [15:0] c, input int unsigned n);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < LANES; i++) begin
      if (i < n) begin
        r = crc_byte(r, 8'h00);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/t10dif_lane.sv
// One byte lane: CRC16 contribution of a single data byte from a zero state.
module t10dif_lane
  import t10dif_pkg::*;
(
  input  logic [7:0]  data_byte,
  output logic [15:0] crc_part
);

  assign crc_part = crc_byte(16'h0000, data_byte);

endmodule

>>> rtl/core/t10dif_tuple_chk.sv
// Guard and tag comparison of one 8-byte protection tuple.
module t10dif_tuple_chk
  import t10dif_pkg::*;
(
  input  logic [63:0] tuple_word,
  input  logic [15:0] running_crc,
  input  logic [15:0] expected_app_tag,
  input  logic [31:0] expected_ref_tag,
  input  chk_cfg_t    cfg,
  output logic [3:0]  error_bits
);

  logic [15:0] guard;
  logic [15:0] app_tag;
  logic [31:0] ref_tag;
  logic [15:0] guard_calc;
  logic        all_ones;
  logic        skip;

  // Tuple fields are big-endian in address order.
  assign guard   = {tuple_word[7:0], tuple_word[15:8]};
  assign app_tag = {tuple_word[23:16], tuple_word[31:24]};
  assign ref_tag = {tuple_word[39:32], tuple_word[47:40], tuple_word[55:48], tuple_word[63:56]};

  assign guard_calc = cfg.mode_flags[FL_INV_RES] ? (running_crc ^ ALL_ONES16) : running_crc;
  assign all_ones   = cfg.mode_flags[FL_F_ALL] && cfg.mode_flags[FL_F_ERR] && (&tuple_word);
  assign skip       = (cfg.mode_flags[FL_F_TAGS] && app_tag == ALL_ONES16 &&
                       ref_tag == ALL_ONES32) ||
                      (cfg.mode_flags[FL_F_APP] && app_tag == ALL_ONES16);

  always_comb begin
    error_bits = 4'b0000;
    if (all_ones) begin
      error_bits[EB_ONES] = 1'b1;
    end else if (!skip) begin
      error_bits[EB_GUARD] = !cfg.mode_flags[FL_NO_GUARD] && (guard_calc != guard);
      error_bits[EB_REF]   = !cfg.mode_flags[FL_NO_REF] && (ref_tag != expected_ref_tag);
      error_bits[EB_APP]   = (cfg.app_mask != 16'h0000) &&
                             (((app_tag ^ expected_app_tag) & ~cfg.app_mask) != 16'h0000);
    end
  end

endmodule

>>> rtl/core/t10_dif_block_checker_core.sv
// Top level of the T10 protection information checker: lanes, merge, job control, output.
// The result is registered when the item carrying tlast is accepted.
// Throughput: one item per cycle; input stalls only while both result slots are full.
// The per-word CRC and the tuple check finish in the cycle the item is accepted.
// Reset (rst, synchronous, active high) loads register defaults and drops all valids.
module t10_dif_block_checker_core
  import t10dif_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_word[63:0]
  input  logic        s_axis_tlast,   // last_word
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[1:0], error_bits[5:2], error_offset[37:6]
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic [12:0] block_bytes;
  logic [9:0]  mode_flags;
  logic [15:0] app_tag_seed;
  logic [15:0] app_tag_ignore_mask;
  logic [31:0] ref_tag_seed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes         <= 13'd512;
      mode_flags          <= '0;
      app_tag_seed        <= '0;
      app_tag_ignore_mask <= '0;
      ref_tag_seed        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_BYTES: block_bytes         <= cfg_data[12:0];
        REG_MODE_FLAGS:  mode_flags          <= cfg_data[9:0];
        REG_APP_SEED:    app_tag_seed        <= cfg_data[15:0];
        REG_APP_MASK:    app_tag_ignore_mask <= cfg_data[15:0];
        REG_REF_SEED:    ref_tag_seed        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Job state.
  logic              job_open;
  logic [POS_W-1:0]  word_position;
  logic [31:0]       block_start_offset;
  logic [15:0]       running_crc;
  logic [15:0]       expected_app_tag;
  logic [31:0]       expected_ref_tag;
  logic [3:0]        latched_error_bits;
  logic [31:0]       latched_error_offset;

  // Block length in words: size rounded down to whole words and clamped to the legal range.
  logic [12:0]      block_clamped;
  logic [POS_W-1:0] data_words;
  logic [31:0]      block_stride;

  always_comb begin
    block_clamped = {block_bytes[12:3], 3'b000};
    if (block_clamped < 13'd8) begin
      block_clamped = 13'd8;
    end else if (block_clamped > 13'(BLOCK_CAP)) begin
      block_clamped = 13'(BLOCK_CAP);
    end
  end

  assign data_words   = POS_W'(block_clamped >> 3);
  assign block_stride = {19'd0, block_clamped} + 32'd8;

  // The first word of a job sees freshly seeded state, so configuration written
  // between jobs takes effect without any explicit clear.
  logic [POS_W-1:0] pos_cur;
  logic [31:0]      off_cur;
  logic [15:0]      app_cur;
  logic [31:0]      ref_cur;
  logic [3:0]       lbits_cur;
  logic [31:0]      loff_cur;
  logic [15:0]      crc_init;
  logic [15:0]      crc_cur;
  logic             is_data;

  assign pos_cur   = job_open ? word_position        : '0;
  assign off_cur   = job_open ? block_start_offset   : '0;
  assign app_cur   = job_open ? expected_app_tag     : app_tag_seed;
  assign ref_cur   = job_open ? expected_ref_tag     : ref_tag_seed;
  assign lbits_cur = job_open ? latched_error_bits   : '0;
  assign loff_cur  = job_open ? latched_error_offset : '0;
  assign crc_init  = mode_flags[FL_INV_SEED] ? ALL_ONES16 : 16'h0000;
  assign crc_cur   = (pos_cur == '0) ? crc_init : running_crc;
  assign is_data   = pos_cur < data_words;

  // Byte lanes. The CRC is linear, so the word update is the old state carried across
  // eight zero bytes, merged with each lane's part carried across the bytes after it.
  logic [15:0] lane_crc [LANES];
  logic [15:0] crc_next;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    t10dif_lane u_lane (
      .data_byte (s_axis_tdata[8*k +: 8]),
      .crc_part  (lane_crc[k])
    );
  end

  always_comb begin
    crc_next = crc_advance(crc_cur, LANES);
    for (int k = 0; k < LANES; k++) begin
      crc_next = crc_next ^ crc_advance(lane_crc[k], LANES - 1 - k);
    end
  end

  // Tuple check, against the CRC finished on the last data word.
  chk_cfg_t   chk_cfg;
  logic [3:0] chk_bits;

  assign chk_cfg.mode_flags = mode_flags;
  assign chk_cfg.app_mask   = app_tag_ignore_mask;

  t10dif_tuple_chk u_tuple_chk (
    .tuple_word       (s_axis_tdata),
    .running_crc      (running_crc),
    .expected_app_tag (app_cur),
    .expected_ref_tag (ref_cur),
    .cfg              (chk_cfg),
    .error_bits       (chk_bits)
  );

  // Only the first failing block is recorded.
  logic        latch_new;
  logic [3:0]  lbits_next;
  logic [31:0] loff_next;
  logic        in_fire;
  logic        push;
  result_t     res_new;

  assign latch_new  = !is_data && (lbits_cur == 4'd0) && (chk_bits != 4'd0);
  assign lbits_next = latch_new ? chk_bits : lbits_cur;
  assign loff_next  = latch_new ? off_cur  : loff_cur;
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign push       = in_fire && s_axis_tlast;

  always_comb begin
    res_new = '0;
    if (is_data) begin
      res_new.status = ST_LEN_ERR;
    end else if (lbits_next != 4'd0) begin
      res_new.status       = ST_DIF_ERR;
      res_new.error_bits   = lbits_next;
      res_new.error_offset = loff_next;
    end else begin
      res_new.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_open <= 1'b0;
    end else if (in_fire) begin
      job_open <= !s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      latched_error_bits   <= lbits_next;
      latched_error_offset <= loff_next;
      if (is_data) begin
        running_crc        <= crc_next;
        word_position      <= pos_cur + 1'b1;
        block_start_offset <= off_cur;
        expected_app_tag   <= app_cur;
        expected_ref_tag   <= ref_cur;
      end else begin
        word_position      <= '0;
        block_start_offset <= off_cur + block_stride;
        expected_app_tag   <= mode_flags[FL_INC_APP] ? app_cur + 16'd1 : app_cur;
        expected_ref_tag   <= mode_flags[FL_FIX_REF] ? ref_cur : ref_cur + 32'd1;
      end
    end
  end

  // Output register plus one skid slot, so input keeps flowing while a result waits.
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_data <= skid_valid ? skid_data : res_new;
    end else if (push) begin
      skid_data <= res_new;
    end
  end

endmodule

>>> rtl/core/t10dif_checker.sv
// Port-level assertions of the T10 protection information checker, bound to the top level.
module t10dif_checker
  import t10dif_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A result waiting on a stalled output keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Error fields are only carried by a DIF error, and the status code is defined.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_DIF_ERR |->
      m_axis_tdata[39:2] == '0 &&
      (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_LEN_ERR))
    else $error("error fields set without a DIF error");

  // A DIF error always names at least one failed check.
  a_dif_bits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_DIF_ERR |-> m_axis_tdata[5:2] != 4'd0)
    else $error("DIF error without error bits");

  // A result only follows the acceptance of a job's last item.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without a last item");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind t10_dif_block_checker_core t10dif_checker u_t10dif_checker (.*);
